@@ rtl/maf_pkg.sv @@
// Shared types and constants for the moving average filter.
// No dependencies; imported by every module of the filter.
package maf_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int CFG_W          = 6;
	localparam int MAX_WINDOW_DEF = 32;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;

	localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = CFG_W'(4);

	// register index decoded from paddr[2]
	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef struct packed {
		logic load;      // capture sample, read oldest slot
		logic update;    // update sum and store, seed divider
		logic div_step;  // one restoring-division step
		logic out_load;  // write result register
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic div_done;
	} sts_t;

endpackage

@@ rtl/moving_average_filter.sv @@
// Boxcar moving average: one result item per sample item, sum / window length.
// Steps: capture the sample, update the sum and store, then run the bit-serial restoring
// divider (SUM_W = 21 at MAX_WINDOW = 32); when disabled the result is loaded straight
// after capture. A new sample is stalled until the last result is loaded, so the divider
// is not overlapped. Reset: async active-low arst_n; window_len returns to 4, sum, write
// position and fill flag clear; store contents are masked until rewritten.
module moving_average_filter #(
	parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [maf_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [maf_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [maf_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready,
	// sample channel
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [maf_pkg::SAMPLE_W-1:0]  sample,
	// result channel
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [maf_pkg::SAMPLE_W-1:0]  average,
	output logic                                 disabled
);
	import maf_pkg::*;

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);

	logic [CFG_W-1:0] window_len_q;
	logic             cfg_wr;
	logic             clear;
	logic [LEN_W-1:0] len;
	cmd_t             cmd;
	sts_t             sts;

	// APB: zero wait states, write on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	// any write to the window length restarts the window from an empty store
	assign clear  = cfg_wr && (paddr[2] == REG_WINDOW_LEN);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WINDOW_LEN) begin
			prdata = APB_DATA_W'(window_len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RESET;
		end else if (clear) begin
			window_len_q <= pwdata[CFG_W-1:0];
		end
	end

	// saturate the programmed length to the store depth; the register keeps its bits
	always_comb begin
		if (int'(window_len_q) > MAX_WINDOW) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(window_len_q);
		end
	end

	// sequencer: handshakes and step order
	maf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// store, running sum, divider and result register
	maf_dp #(
		.MAX_WINDOW (MAX_WINDOW),
		.LEN_W      (LEN_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.clear    (clear),
		.len      (len),
		.sample   (sample),
		.average  (average),
		.disabled (disabled)
	);

endmodule

@@ rtl/maf_ctrl.sv @@
// Sequencer for the moving average filter: input/output handshake and step control.
// Depends on maf_pkg (cmd_t, sts_t).
module maf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	output logic          sample_stall,
	output logic          result_valid,
	input  logic          result_stall,
	input  maf_pkg::sts_t sts,
	output maf_pkg::cmd_t cmd
);
	import maf_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		UPDATE,
		DIVIDE,
		FINISH
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign sample_stall = (state_q != IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			IDLE: begin
				if (sample_valid) begin
					cmd.load   = 1'b1;
					state_next = sts.len_zero ? FINISH : UPDATE;
				end
			end
			UPDATE: begin
				cmd.update = 1'b1;
				state_next = DIVIDE;
			end
			DIVIDE: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_next = FINISH;
				end
			end
			FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_next   = IDLE;
				end
			end
			default: state_next = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == FINISH)
		else $error("result raised outside FINISH");

	a_finish_loads_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FINISH) && out_free |=> out_valid_q && (state_q == IDLE))
		else $error("free output register not loaded");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIVIDE) && !sts.div_done |=> sample_stall)
		else $error("input accepted during division");

endmodule

@@ rtl/maf_dp.sv @@
// Datapath of the moving average filter: sample store, running sum,
// serial restoring divider and result register. Depends on maf_pkg.
module maf_dp #(
	parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF,
	parameter int LEN_W      = $clog2(MAX_WINDOW + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  maf_pkg::cmd_t                     cmd,
	output maf_pkg::sts_t                     sts,
	input  logic                              clear,
	input  logic [LEN_W-1:0]                  len,
	input  logic signed [maf_pkg::SAMPLE_W-1:0] sample,
	output logic signed [maf_pkg::SAMPLE_W-1:0] average,
	output logic                              disabled
);
	import maf_pkg::*;

	localparam int ADDR_W = $clog2(MAX_WINDOW);
	localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(SUM_W);

	logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];

	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic [ADDR_W-1:0]          wpos_q;
	logic                       wrapped_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]           quo_q;
	logic [LEN_W-1:0]           rem_q;
	logic                       neg_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SAMPLE_W-1:0] average_q;
	logic                       disabled_q;

	logic signed [SAMPLE_W-1:0] old_sample;
	logic signed [SUM_W-1:0]    sum_new;
	logic [SUM_W-1:0]           sum_mag;
	logic [LEN_W-1:0]           wpos_inc;
	logic                       wrap;
	logic [LEN_W:0]             rem_shift;
	logic                       rem_ge;
	logic [SUM_W-1:0]           quo_signed;

	// a slot is only ever written in order from zero, so before the first
	// wrap the slot at the write position is unwritten since the clear and counts as zero
	assign old_sample = wrapped_q ? rd_q : '0;
	assign sum_new    = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
	assign sum_mag    = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
	assign wpos_inc   = LEN_W'(wpos_q) + LEN_W'(1);
	assign wrap       = (wpos_inc >= len);
	assign rem_shift  = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge     = (rem_shift >= {1'b0, len});
	assign quo_signed = neg_q ? SUM_W'(-quo_q) : quo_q;

	assign sts.len_zero = (len == '0);
	assign sts.div_done = (cnt_q == '0);
	assign average      = average_q;
	assign disabled     = disabled_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
			rd_q     <= mem[wpos_q];
		end
		if (cmd.update) begin
			mem[wpos_q] <= sample_q;
		end
		if (cmd.out_load) begin
			average_q  <= sts.len_zero ? '0 : quo_signed[SAMPLE_W-1:0];
			disabled_q <= sts.len_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			neg_q     <= 1'b0;
			cnt_q     <= '0;
		end else if (clear) begin
			wpos_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			rem_q     <= '0;
		end else if (cmd.update) begin
			sum_q  <= sum_new;
			wpos_q <= wrap ? '0 : wpos_inc[ADDR_W-1:0];
			if (wrap) begin
				wrapped_q <= 1'b1;
			end
			quo_q <= sum_mag;
			neg_q <= sum_new[SUM_W-1];
			rem_q <= '0;
			cnt_q <= CNT_W'(SUM_W - 1);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? LEN_W'(rem_shift - {1'b0, len}) : rem_shift[LEN_W-1:0];
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_wpos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.len_zero |-> LEN_W'(wpos_q) < len)
		else $error("write position outside window");

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.len_zero |-> rem_q < len)
		else $error("divider remainder not reduced");

	a_wrapped_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q && !clear |=> wrapped_q)
		else $error("fill flag dropped without clear");

endmodule
